### rtl/u2f_pkg.sv
// ----------------------------------------------------------------------------
// u2f_pkg: shared definitions for the UTF-8 to Fibonacci code transcoder.
// Holds the status codes, the Fibonacci term table, the widths of the
// serial encoder and the control structs between the top level and the packer.
// ----------------------------------------------------------------------------
package u2f_pkg;

	// Status codes reported in the error_code field.
	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_LEAD  = 3'd1;
	localparam logic [2:0] ERR_CONT  = 3'd2;
	localparam logic [2:0] ERR_TRUNC = 3'd3;
	localparam logic [2:0] ERR_RANGE = 3'd4;

	// Code point limits and encoder geometry.
	localparam int unsigned VAL_W     = 21;
	localparam logic [VAL_W-1:0] MAX_CP = 21'h10FFFF;
	localparam int unsigned NUM_TERMS = 29;
	localparam int unsigned TERM_W    = 20;
	localparam int unsigned IDX_W     = 5;
	// Code word: one bit per term plus the terminating one.
	localparam int unsigned CODE_W    = NUM_TERMS + 1;
	localparam int unsigned LEN_W     = 5;
	localparam int unsigned BYTE_BITS = 8;

	// Command from the sequencer to the byte packer.
	typedef struct packed {
		logic       push;
		logic       bit_val;
		logic       byte_last;
		logic       flush;
		logic       status;
		logic [2:0] err;
	} pk_cmd_t;

	// Status returned by the byte packer.
	typedef struct packed {
		logic bit_ok;
		logic out_free;
		logic has_bits;
	} pk_stat_t;

	// Fibonacci terms 1, 2, 3, 5, ... used by the greedy Zeckendorf search.
	function automatic logic [TERM_W-1:0] fib_term(input logic [IDX_W-1:0] idx);
		logic [TERM_W-1:0] t;
		case (idx)
			5'd0:  t = 20'd1;
			5'd1:  t = 20'd2;
			5'd2:  t = 20'd3;
			5'd3:  t = 20'd5;
			5'd4:  t = 20'd8;
			5'd5:  t = 20'd13;
			5'd6:  t = 20'd21;
			5'd7:  t = 20'd34;
			5'd8:  t = 20'd55;
			5'd9:  t = 20'd89;
			5'd10: t = 20'd144;
			5'd11: t = 20'd233;
			5'd12: t = 20'd377;
			5'd13: t = 20'd610;
			5'd14: t = 20'd987;
			5'd15: t = 20'd1597;
			5'd16: t = 20'd2584;
			5'd17: t = 20'd4181;
			5'd18: t = 20'd6765;
			5'd19: t = 20'd10946;
			5'd20: t = 20'd17711;
			5'd21: t = 20'd28657;
			5'd22: t = 20'd46368;
			5'd23: t = 20'd75025;
			5'd24: t = 20'd121393;
			5'd25: t = 20'd196418;
			5'd26: t = 20'd317811;
			5'd27: t = 20'd514229;
			5'd28: t = 20'd832040;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

### rtl/u2f_zeck.sv
// ----------------------------------------------------------------------------
// u2f_zeck: serial Zeckendorf encoder.
// Runs the greedy term search one Fibonacci term per cycle, from the highest
// term down, then shifts the code out, lowest first, one bit a cycle on pop.
// ----------------------------------------------------------------------------
module u2f_zeck (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [u2f_pkg::VAL_W-1:0]       n_in,
	input  logic                            pop,
	output logic                            busy,
	output logic                            bit_valid,
	output logic                            bit_out,
	output logic [u2f_pkg::LEN_W-1:0]       bits_left
);

	typedef enum logic [1:0] {ZK_IDLE, ZK_CALC, ZK_SHIFT} zk_state_t;

	zk_state_t                        state_q;
	logic [u2f_pkg::VAL_W-1:0]        rem_q;
	logic [u2f_pkg::IDX_W-1:0]        idx_q;
	logic [u2f_pkg::IDX_W-1:0]        top_q;
	logic                             seen_q;
	logic [u2f_pkg::CODE_W-1:0]       code_q;
	logic [u2f_pkg::LEN_W-1:0]        len_q;

	logic [u2f_pkg::VAL_W-1:0]        term;
	logic                             take;
	logic [u2f_pkg::IDX_W-1:0]        top_n;
	logic [u2f_pkg::CODE_W-1:0]       code_set;

	// One compare and subtract against the current term.
	always_comb begin
		term     = {1'b0, u2f_pkg::fib_term(idx_q)};
		take     = (rem_q >= term);
		top_n    = (take && !seen_q) ? idx_q : top_q;
		code_set = code_q | (take ? (u2f_pkg::CODE_W'(1) << idx_q) : '0);
	end

	// Search sequencer and output shift register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ZK_IDLE;
			rem_q   <= '0;
			idx_q   <= '0;
			top_q   <= '0;
			seen_q  <= 1'b0;
			code_q  <= '0;
			len_q   <= '0;
		end else begin
			case (state_q)
				ZK_IDLE: begin
					if (start) begin
						rem_q   <= n_in;
						idx_q   <= u2f_pkg::IDX_W'(u2f_pkg::NUM_TERMS - 1);
						top_q   <= '0;
						seen_q  <= 1'b0;
						code_q  <= '0;
						state_q <= ZK_CALC;
					end
				end
				ZK_CALC: begin
					if (take) begin
						rem_q <= rem_q - term;
					end
					seen_q <= seen_q | take;
					top_q  <= top_n;
					if (idx_q == '0) begin
						// Append the terminating one just above the highest term.
						code_q  <= code_set |
							(u2f_pkg::CODE_W'(1) << u2f_pkg::IDX_W'(top_n + 5'd1));
						len_q   <= u2f_pkg::LEN_W'(top_n + 5'd2);
						state_q <= ZK_SHIFT;
					end else begin
						code_q <= code_set;
						idx_q  <= idx_q - 5'd1;
					end
				end
				ZK_SHIFT: begin
					if (pop) begin
						code_q <= code_q >> 1;
						len_q  <= len_q - 5'd1;
						if (len_q == 5'd1) begin
							state_q <= ZK_IDLE;
						end
					end
				end
				default: begin
					state_q <= ZK_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ZK_IDLE);
	assign bit_valid = (state_q == ZK_SHIFT);
	assign bit_out   = code_q[0];
	assign bits_left = len_q;

	// A new search starts only when the previous code word is fully shifted out.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == ZK_IDLE))
		else $error("encoder started while busy");

	// The shift phase always has at least one bit left.
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ZK_SHIFT) |-> (len_q != '0))
		else $error("shift phase with empty code word");

endmodule

### rtl/u2f_pack.sv
// ----------------------------------------------------------------------------
// u2f_pack: bit packer and output register.
// Gathers code bits LSB first into bytes, emits full bytes, flushes the
// padded partial byte and emits status beats through one output register.
// ----------------------------------------------------------------------------
module u2f_pack (
	input  logic              clk,
	input  logic              arst_n,
	input  u2f_pkg::pk_cmd_t  cmd,
	output u2f_pkg::pk_stat_t stat,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              byte_valid,
	output logic [2:0]        error_code,
	output logic              last
);

	logic [u2f_pkg::BYTE_BITS-2:0] buf_q;
	logic [2:0]                    cnt_q;
	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;
	logic                          byte_valid_q;
	logic [2:0]                    error_code_q;
	logic                          last_q;

	logic out_free;
	logic bit_ok;
	logic out_load;

	// The output register can load when empty or being taken this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign bit_ok   = (cnt_q != 3'd7) || out_free;

	// A new beat enters the output register this cycle.
	assign out_load = (cmd.push && bit_ok) ? (cnt_q == 3'd7)
	                                       : ((cmd.flush || cmd.status) && out_free);

	assign stat.bit_ok   = bit_ok;
	assign stat.out_free = out_free;
	assign stat.has_bits = (cnt_q != '0);

	// Bit buffer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q        <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			byte_valid_q <= 1'b0;
			error_code_q <= u2f_pkg::ERR_NONE;
			last_q       <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.push && bit_ok) begin
				if (cnt_q == 3'd7) begin
					out_byte_q   <= {cmd.bit_val, buf_q};
					byte_valid_q <= 1'b1;
					error_code_q <= u2f_pkg::ERR_NONE;
					last_q       <= cmd.byte_last;
					buf_q        <= '0;
					cnt_q        <= '0;
				end else begin
					buf_q[cnt_q] <= cmd.bit_val;
					cnt_q        <= cnt_q + 3'd1;
				end
			end else if (cmd.flush && out_free) begin
				out_byte_q   <= {1'b0, buf_q};
				byte_valid_q <= 1'b1;
				error_code_q <= u2f_pkg::ERR_NONE;
				last_q       <= 1'b0;
				buf_q        <= '0;
				cnt_q        <= '0;
			end else if (cmd.status && out_free) begin
				out_byte_q   <= '0;
				byte_valid_q <= 1'b0;
				error_code_q <= cmd.err;
				last_q       <= 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign error_code = error_code_q;
	assign last       = last_q;

	// A data beat never carries an error code.
	a_data_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && byte_valid_q) |-> (error_code_q == u2f_pkg::ERR_NONE))
		else $error("data beat with error code");

endmodule

### rtl/utf8_to_fibonacci_encoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_fibonacci_encoder_top: UTF-8 to Fibonacci code transcoder.
// Input beats carry one UTF-8 byte or an end-of-stream marker. Each complete
// character is encoded as the Zeckendorf code of code point plus one, lowest
// term first, with a terminating one, and packed LSB first into output beats.
// Output beats carry a data byte (byte_valid = 1) or a status (byte_valid = 0)
// with error_code; last marks the final beat caused by one input beat.
// Per accepted input beat: a lead or continuation byte that does not complete
// a character only updates the character state. A completed character runs
// the greedy term search over all 29 terms in the serial encoder, then
// shifts its top+2 code bits (2 to 30) into the packer, one per cycle while
// the packer takes them, before the input is released. A byte that raises
// an error gives a status beat, an end marker a flush beat (if bits remain)
// and a status beat. Input stall is high while a beat is in work; one item
// is handled at a time.
// A stall on the output holds the output register; the packer then stops
// taking code bits once a full byte waits, and the encoder waits with it.
// Reset clears the character state, bit buffer, sticky error and output valid.
// ----------------------------------------------------------------------------
module utf8_to_fibonacci_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_stream,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic [2:0] error_code,
	output logic       last
);

	typedef enum logic [1:0] {ST_IDLE, ST_ZECK, ST_FLUSH, ST_STATUS} st_t;

	st_t                           state_q;
	logic [u2f_pkg::VAL_W-1:0]     value_q;
	logic [1:0]                    pend_q;
	logic [2:0]                    err_q;
	logic [2:0]                    stat_err_q;
	logic                          eos_q;

	logic                          accept;
	logic                          cont_ok;
	logic [u2f_pkg::VAL_W-1:0]     value_cat;
	logic                          zk_start;
	logic [u2f_pkg::VAL_W-1:0]     zk_n;
	logic                          zk_busy;
	logic                          zk_bit_valid;
	logic                          zk_bit;
	logic [u2f_pkg::LEN_W-1:0]     zk_left;
	logic                          zk_pop;
	u2f_pkg::pk_cmd_t              pk_cmd;
	u2f_pkg::pk_stat_t             pk_stat;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Character assembly and encoder start decision.
	always_comb begin
		cont_ok   = (data_byte[7:6] == 2'b10);
		value_cat = {value_q[u2f_pkg::VAL_W-7:0], data_byte[5:0]};
		zk_n      = (pend_q == 2'd0) ? (u2f_pkg::VAL_W'(data_byte) + 21'd1)
		                             : (value_cat + 21'd1);
		zk_start  = accept && !end_of_stream && (err_q == u2f_pkg::ERR_NONE) &&
			(((pend_q == 2'd0) && !data_byte[7]) ||
			 ((pend_q == 2'd1) && cont_ok && (value_cat <= u2f_pkg::MAX_CP)));
	end

	// Packer commands and encoder bit handoff.
	always_comb begin
		pk_cmd.push      = (state_q == ST_ZECK) && zk_bit_valid;
		pk_cmd.bit_val   = zk_bit;
		pk_cmd.byte_last = (zk_left <= 5'd8);
		pk_cmd.flush     = (state_q == ST_FLUSH) && pk_stat.has_bits;
		pk_cmd.status    = (state_q == ST_STATUS);
		pk_cmd.err       = stat_err_q;
		zk_pop           = pk_cmd.push && pk_stat.bit_ok;
	end

	// Sequencer: character state, sticky error and beat order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			value_q    <= '0;
			pend_q     <= '0;
			err_q      <= u2f_pkg::ERR_NONE;
			stat_err_q <= u2f_pkg::ERR_NONE;
			eos_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (end_of_stream) begin
							stat_err_q <= ((err_q == u2f_pkg::ERR_NONE) && (pend_q != 2'd0))
								? u2f_pkg::ERR_TRUNC : err_q;
							eos_q      <= 1'b1;
							state_q    <= ST_FLUSH;
						end else if (err_q != u2f_pkg::ERR_NONE) begin
							// Bytes after an error are dropped until the end marker.
							state_q <= ST_IDLE;
						end else if (pend_q == 2'd0) begin
							if (!data_byte[7]) begin
								state_q <= ST_ZECK;
							end else if (data_byte[7:5] == 3'b110) begin
								pend_q  <= 2'd1;
								value_q <= u2f_pkg::VAL_W'(data_byte[4:0]);
							end else if (data_byte[7:4] == 4'b1110) begin
								pend_q  <= 2'd2;
								value_q <= u2f_pkg::VAL_W'(data_byte[3:0]);
							end else if (data_byte[7:3] == 5'b11110) begin
								pend_q  <= 2'd3;
								value_q <= u2f_pkg::VAL_W'(data_byte[2:0]);
							end else begin
								err_q      <= u2f_pkg::ERR_LEAD;
								stat_err_q <= u2f_pkg::ERR_LEAD;
								eos_q      <= 1'b0;
								state_q    <= ST_STATUS;
							end
						end else if (!cont_ok) begin
							err_q      <= u2f_pkg::ERR_CONT;
							stat_err_q <= u2f_pkg::ERR_CONT;
							eos_q      <= 1'b0;
							pend_q     <= '0;
							value_q    <= '0;
							state_q    <= ST_STATUS;
						end else begin
							pend_q <= pend_q - 2'd1;
							if (pend_q == 2'd1) begin
								value_q <= '0;
								if (value_cat > u2f_pkg::MAX_CP) begin
									err_q      <= u2f_pkg::ERR_RANGE;
									stat_err_q <= u2f_pkg::ERR_RANGE;
									eos_q      <= 1'b0;
									state_q    <= ST_STATUS;
								end else begin
									state_q <= ST_ZECK;
								end
							end else begin
								value_q <= value_cat;
							end
						end
					end
				end
				ST_ZECK: begin
					if (!zk_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (!pk_stat.has_bits || pk_stat.out_free) begin
						state_q <= ST_STATUS;
					end
				end
				ST_STATUS: begin
					if (pk_stat.out_free) begin
						if (eos_q) begin
							value_q <= '0;
							pend_q  <= '0;
							err_q   <= u2f_pkg::ERR_NONE;
							eos_q   <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	u2f_zeck u_zeck (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (zk_start),
		.n_in      (zk_n),
		.pop       (zk_pop),
		.busy      (zk_busy),
		.bit_valid (zk_bit_valid),
		.bit_out   (zk_bit),
		.bits_left (zk_left)
	);

	u2f_pack u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (pk_cmd),
		.stat       (pk_stat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.error_code (error_code),
		.last       (last)
	);

	// No input beat is taken while the encoder still works on a character.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !zk_busy)
		else $error("input beat accepted while encoder busy");

endmodule
